### src/mclb_pkg.sv
// Shared types and constants for the multi-channel LED blinker.
// No dependencies; used by mclb_channel and multi_channel_led_blinker_top.
`default_nettype none

package mclb_pkg;

    localparam int DEFAULT_CHANNELS = 4;
    localparam int TICK_W           = 16;
    localparam int OP_W             = 2;
    localparam int CH_W             = 2;
    localparam int RESULT_W         = 4;

    // Operation codes carried in s_tuser
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_SET   = 2'd2;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // Decoded command broadcast to every channel
    typedef struct packed {
        logic              tick;
        logic              start;
        logic              set;
        logic [CH_W-1:0]   channel;
        logic [TICK_W-1:0] on_time;
        logic [TICK_W-1:0] off_time;
        logic [TICK_W-1:0] repeat_count;
        logic              level;
    } cmd_t;

    // Per-channel status after the command is applied
    typedef struct packed {
        logic led;
        logic active;
    } chan_status_t;

endpackage

`default_nettype wire

### src/mclb_channel.sv
// One blink channel: on/off thresholds, pulse counter, elapsed counter, LED bit.
// Depends on mclb_pkg (cmd_t, chan_status_t, tick constants).
`default_nettype none

module mclb_channel (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  sel,
    input  wire mclb_pkg::cmd_t        cmd,
    output mclb_pkg::chan_status_t     status
);

    logic                        active_reg, active_next;
    logic                        phase_reg, phase_next;
    logic                        led_reg, led_next;
    logic                        endless_reg, endless_next;
    logic [mclb_pkg::TICK_W-1:0] on_reg, on_next;
    logic [mclb_pkg::TICK_W-1:0] off_reg, off_next;
    logic [mclb_pkg::TICK_W-1:0] pulses_reg, pulses_next;
    logic [mclb_pkg::TICK_W-1:0] elapsed_reg, elapsed_next;

    logic [mclb_pkg::TICK_W-1:0] elapsed_inc;
    logic [mclb_pkg::TICK_W-1:0] limit;
    logic [mclb_pkg::TICK_W-1:0] pulses_dec;

    assign elapsed_inc = (elapsed_reg == mclb_pkg::TICK_MAX) ? elapsed_reg
                                                             : elapsed_reg + 1'b1;
    assign limit       = phase_reg ? on_reg : off_reg;
    assign pulses_dec  = (pulses_reg != '0) ? pulses_reg - 1'b1 : pulses_reg;

    always_comb begin
        active_next  = active_reg;
        phase_next   = phase_reg;
        led_next     = led_reg;
        endless_next = endless_reg;
        on_next      = on_reg;
        off_next     = off_reg;
        pulses_next  = pulses_reg;
        elapsed_next = elapsed_reg;
        if (cmd.tick) begin
            if (active_reg) begin
                if (elapsed_inc >= limit) begin
                    phase_next   = !phase_reg;
                    led_next     = !phase_reg;
                    elapsed_next = '0;
                    // off-to-on edge consumes one pulse unless endless
                    if (!phase_reg && !endless_reg) begin
                        pulses_next = pulses_dec;
                        if (pulses_dec == '0) begin
                            active_next = 1'b0;
                            led_next    = 1'b0;
                        end
                    end
                end else begin
                    elapsed_next = elapsed_inc;
                end
            end
        end else if (cmd.start && sel) begin
            active_next  = 1'b1;
            phase_next   = 1'b1;
            led_next     = 1'b1;
            on_next      = cmd.on_time;
            off_next     = cmd.off_time;
            endless_next = (cmd.repeat_count == '0);
            pulses_next  = cmd.repeat_count;
            elapsed_next = '0;
        end else if (cmd.set && sel) begin
            led_next = cmd.level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            phase_reg  <= 1'b0;
            led_reg    <= 1'b0;
        end else if (en) begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            led_reg    <= led_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            endless_reg <= endless_next;
            on_reg      <= on_next;
            off_reg     <= off_next;
            pulses_reg  <= pulses_next;
            elapsed_reg <= elapsed_next;
        end
    end

    assign status.led    = led_next;
    assign status.active = active_next;

endmodule

`default_nettype wire

### src/multi_channel_led_blinker_top.sv
// Multi-channel LED blinker: input register, per-channel update, result register.
// An s_ transfer enters the input register, then its result the result register;
// one item per cycle unless m_tready stalls, via the single per-channel update between them.
// Reset (aresetn low, synchronous) empties both registers, stops all channels
// and turns every LED off. Depends on mclb_pkg and mclb_channel.
`default_nettype none

module multi_channel_led_blinker_top #(
    parameter int CHANNELS = mclb_pkg::DEFAULT_CHANNELS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] on_time, [31:16] off_time, [47:32] repeat_count, [48] level
    input  wire logic [55:0] s_tdata,
    // [1:0] op, [3:2] channel
    input  wire logic [3:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [3:0] led_levels, [7:4] active_mask
    output logic [7:0]       m_tdata
);

    logic                          in_valid_reg;
    logic [55:0]                   in_data_reg;
    logic [3:0]                    in_user_reg;
    logic                          out_valid_reg;
    logic [7:0]                    out_data_reg;
    logic                          advance;
    mclb_pkg::cmd_t                cmd;
    mclb_pkg::chan_status_t        status [CHANNELS];
    logic [mclb_pkg::RESULT_W-1:0] led_bits;
    logic [mclb_pkg::RESULT_W-1:0] act_bits;
    logic [mclb_pkg::OP_W-1:0]     op;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
    end

    assign op               = in_user_reg[1:0];
    assign cmd.tick         = (op == mclb_pkg::OP_TICK);
    assign cmd.start        = (op == mclb_pkg::OP_START);
    assign cmd.set          = (op == mclb_pkg::OP_SET);
    assign cmd.channel      = in_user_reg[3:2];
    assign cmd.on_time      = in_data_reg[15:0];
    assign cmd.off_time     = in_data_reg[31:16];
    assign cmd.repeat_count = in_data_reg[47:32];
    assign cmd.level        = in_data_reg[48];

    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        mclb_channel u_chan (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (advance),
            .sel     (32'(cmd.channel) == c),
            .cmd     (cmd),
            .status  (status[c])
        );
    end

    // Only the low channels fit in the result fields
    for (genvar i = 0; i < mclb_pkg::RESULT_W; i++) begin : g_res
        if (i < CHANNELS) begin : g_used
            assign led_bits[i] = status[i].led;
            assign act_bits[i] = status[i].active;
        end else begin : g_pad
            assign led_bits[i] = 1'b0;
            assign act_bits[i] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {act_bits, led_bits};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire
